/* sv/lkvc_pkg.sv */
// Shared types and constants for the LRU key/value cache.
// Used by the cell row, the top level and the testbench.
package lkvc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int CFG_W           = 5;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;
    localparam logic [31:0]      MISS_VALUE     = 32'hFFFF_FFFF;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_entry;

endpackage

/* sv/lru_key_value_cache_core.sv */
// Top level of the LRU key/value cache: request handling, replacement
// decision and the row of lkvc_cell storage cells.
// Depends on lkvc_pkg and lkvc_cell.

// Fully associative key/value store with least-recently-used replacement.
// Each input beat is a get or a put and yields exactly one output beat.
// Entries live in a row of MAX_ENTRIES cells kept in recency order: cell 0
// holds the most recent entry and valid entries always form a prefix of the
// row. A hit, an insert or an eviction at row position p shifts cells 0..p-1
// one place down the row and loads the touched entry into cell 0; the
// least recent entry is therefore always the last valid cell. A put of a
// new key evicts that entry once the entry count has reached the capacity
// register (0 acts as 1, values above MAX_ENTRIES saturate); lowering the
// capacity drops nothing at once. Each item is first accepted and its
// request registered; then every cell compares its key in parallel, the
// shift is applied and the result is loaded into the output register.
// A new beat is accepted once the result has moved into the
// output register, so a stalled consumer holds the block only while a
// second result is ready to leave. The capacity register is written
// through its own channel, which is always ready; write it only while idle.
module lru_key_value_cache_core
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit,
    output logic signed [31:0] o_read_value,
    output logic               o_evicted,
    output logic signed [31:0] o_evicted_key
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // registered request
    logic               r_kind;
    logic signed [31:0] r_key;
    logic signed [31:0] r_value;

    logic [CFG_W-1:0]   r_capacity;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    // output register
    logic               r_out_valid;
    logic               r_hit;
    logic signed [31:0] r_read_value;
    logic               r_evicted;
    logic signed [31:0] r_evicted_key;

    // cell row
    t_entry                 w_ent [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_match;
    logic [MAX_ENTRIES-1:0] w_tail;
    logic [MAX_ENTRIES-1:0] w_take;
    t_entry                 w_front;

    logic               w_in_beat;
    logic               w_exec;
    logic               w_any_hit;
    logic [IDX_W-1:0]   w_hit_pos;
    logic signed [31:0] w_hit_val;
    logic signed [31:0] w_tail_key;
    logic [CMP_W-1:0]   w_cap_eff;
    logic               w_room;
    logic [CNT_W-1:0]   w_cnt_m1;
    logic               w_upd;
    logic [IDX_W-1:0]   w_pos;
    logic               w_inc;
    logic               w_res_hit;
    logic signed [31:0] w_res_rd;
    logic               w_res_ev;
    logic signed [31:0] w_res_evk;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_beat   = i_in_valid && o_in_ready;
    // finish the item only when the output register is free or draining
    assign w_exec      = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    // ---------------------------------------------------------------
    // Cell row: cell 0 loads the touched entry, cell g>0 takes cell g-1.
    // ---------------------------------------------------------------
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        t_entry w_src;

        if (g == 0) begin : g_head
            assign w_src = w_front;
        end else begin : g_body
            assign w_src = w_ent[g-1];
        end

        // last valid cell holds the least recent entry
        if (g == MAX_ENTRIES - 1) begin : g_last
            assign w_tail[g] = w_ent[g].valid;
        end else begin : g_mid
            assign w_tail[g] = w_ent[g].valid && !w_ent[g+1].valid;
        end

        assign w_take[g] = w_upd && (IDX_W'(g) <= w_pos);

        lkvc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_take    (w_take[g]),
            .i_src     (w_src),
            .i_req_key (r_key),
            .o_ent     (w_ent[g]),
            .o_match   (w_match[g])
        );
    end

    // Keys are unique among valid cells, so at most one match: OR-combine.
    always_comb begin
        w_hit_pos  = '0;
        w_hit_val  = '0;
        w_tail_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hit_pos = w_hit_pos | IDX_W'(i);
                w_hit_val = w_hit_val | w_ent[i].value;
            end
            if (w_tail[i]) begin
                w_tail_key = w_tail_key | w_ent[i].key;
            end
        end
    end

    assign w_any_hit = |w_match;

    // Clamp capacity into 1..MAX_ENTRIES.
    always_comb begin
        priority if (r_capacity == '0) begin
            w_cap_eff = CMP_W'(1);
        end else if (CMP_W'(r_capacity) > CMP_W'(MAX_ENTRIES)) begin
            w_cap_eff = CMP_W'(MAX_ENTRIES);
        end else begin
            w_cap_eff = CMP_W'(r_capacity);
        end
    end

    assign w_room   = CMP_W'(r_count) < w_cap_eff;
    assign w_cnt_m1 = r_count - CNT_W'(1);

    // Replacement decision: pick the row position to promote from.
    always_comb begin
        w_upd     = 1'b0;
        w_pos     = w_hit_pos;
        w_inc     = 1'b0;
        w_res_hit = w_any_hit;
        w_res_rd  = MISS_VALUE;
        w_res_ev  = 1'b0;
        w_res_evk = '0;
        w_front   = '{valid: 1'b1, key: r_key, value: w_hit_val};
        if (r_kind == KIND_PUT) begin
            w_res_rd      = r_value;
            w_front.value = r_value;
            priority if (w_any_hit) begin
                w_upd = 1'b1;
            end else if (w_room) begin
                // insert at the first free cell, everything ahead moves back
                w_upd = 1'b1;
                w_pos = r_count[IDX_W-1:0];
                w_inc = 1'b1;
            end else begin
                // evict the least recent entry at the end of the valid prefix
                w_upd     = 1'b1;
                w_pos     = w_cnt_m1[IDX_W-1:0];
                w_res_ev  = 1'b1;
                w_res_evk = w_tail_key;
            end
        end else if (w_any_hit) begin
            w_upd    = 1'b1;
            w_res_rd = w_hit_val;
        end
        w_upd = w_upd && w_exec;
    end

    assign n_count = (w_exec && w_inc) ? r_count + CNT_W'(1) : r_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_beat) n_state = ST_EXEC;
            ST_EXEC: if (w_exec)    n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_capacity  <= CAPACITY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: hold the request beat, load results when the item finishes.
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (w_exec) begin
            r_hit         <= w_res_hit;
            r_read_value  <= w_res_rd;
            r_evicted     <= w_res_ev;
            r_evicted_key <= w_res_evk;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

endmodule

/* sv/lkvc_cell.sv */
// One storage cell of the recency-ordered row: holds an entry, compares
// its key against the request and takes its neighbor's entry on a shift.
// Depends on lkvc_pkg.
module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  t_entry             i_src,
    input  logic signed [31:0] i_req_key,
    output t_entry             o_ent,
    output logic               o_match
);

    logic               r_valid;
    logic               n_valid;
    logic signed [31:0] r_key;
    logic signed [31:0] n_key;
    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    always_comb begin
        n_valid = i_take ? i_src.valid : r_valid;
        n_key   = i_take ? i_src.key   : r_key;
        n_value = i_take ? i_src.value : r_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_ent   = '{valid: r_valid, key: r_key, value: r_value};
    assign o_match = r_valid && (r_key == i_req_key);

endmodule

/* sv/lkvc_chk.sv */
// Port-level checker for the LRU key/value cache, bound to the top level.
// Sees only the top level's ports; depends on lru_key_value_cache_core.
module lkvc_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_hit,
    input logic signed [31:0] o_read_value,
    input logic               o_evicted,
    input logic signed [31:0] o_evicted_key
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit)
            && $stable(o_read_value) && $stable(o_evicted) && $stable(o_evicted_key))
        else $error("result beat changed while stalled");

    // no evicted key without an eviction
    a_evk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted |-> o_evicted_key == 32'sd0)
        else $error("evicted key set without eviction");

    // an eviction only happens on a put that missed
    a_ev_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> !o_hit)
        else $error("eviction reported on a hit");

    // one item at a time: a request beat closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request accepted while busy");

endmodule

bind lru_key_value_cache_core lkvc_chk u_lkvc_chk (.*);

/* dv/lru_key_value_cache_core_test.sv */
// Self-checking testbench for lru_key_value_cache_core: random get/put traffic
// against an in-bench LRU predictor, with random gaps and stalls on both channels.
// Depends on lkvc_pkg and the RTL of lru_key_value_cache_core.
module lru_key_value_cache_core_test;
    import lkvc_pkg::*;

    localparam int SLOTS = MAX_ENTRIES_DEF;

    typedef struct {
        logic        kind;
        logic [31:0] key;
        logic [31:0] value;
    } t_cache_req;

    typedef struct {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } t_cache_reply;

    // DUT ports, inputs known from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_kind = KIND_GET;
    logic signed [31:0] i_key = '0;
    logic signed [31:0] i_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_hit;
    logic signed [31:0] o_read_value;
    logic               o_evicted;
    logic signed [31:0] o_evicted_key;

    // Predictor state: one row of slots with an age per slot (0 = most recent)
    logic [31:0]      slot_key [SLOTS];
    logic [31:0]      slot_val [SLOTS];
    logic             slot_used[SLOTS];
    int               slot_age [SLOTS];
    int               used_count = 0;
    logic [CFG_W-1:0] cap_setting = CAPACITY_RESET;

    t_cache_req   pending_ops[$];
    t_cache_reply replies_due[$];
    logic [31:0]  key_pool[32];

    int  mismatches = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    // when set, neither side idles: run back-to-back beats
    bit  calm = 1'b0;

    lru_key_value_cache_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly no idling, often a short gap, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Capacity as the block applies it: zero acts as one, saturate at the row size.
    function automatic int usable_slots();
        if (cap_setting == 0) return 1;
        if (cap_setting > SLOTS) return SLOTS;
        return int'(cap_setting);
    endfunction

    // Move slot s to the front; every valid slot younger than limit ages by one.
    function automatic void touch_slot(int s, int limit);
        for (int i = 0; i < SLOTS; i++) begin
            if (i != s && slot_used[i] && slot_age[i] < limit) slot_age[i]++;
        end
        slot_age[s] = 0;
    endfunction

    // Apply one request to the predictor and queue the reply it must produce.
    task automatic lru_access(input logic kind, input logic [31:0] key,
                              input logic [31:0] value);
        t_cache_reply rep;
        int s;
        int f;
        int v;
        rep.hit = 1'b0;
        rep.read_value = MISS_VALUE;
        rep.evicted = 1'b0;
        rep.evicted_key = '0;
        s = -1;
        f = -1;
        v = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (s < 0 && slot_used[i] && slot_key[i] == key) s = i;
        end
        if (kind == KIND_GET) begin
            if (s >= 0) begin
                rep.hit = 1'b1;
                rep.read_value = slot_val[s];
                touch_slot(s, slot_age[s]);
            end
        end else begin
            rep.read_value = value;
            if (s >= 0) begin
                rep.hit = 1'b1;
                slot_val[s] = value;
                touch_slot(s, slot_age[s]);
            end else begin
                if (used_count < usable_slots()) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (f < 0 && !slot_used[i]) f = i;
                    end
                end
                if (f >= 0) begin
                    slot_used[f] = 1'b1;
                    slot_key[f] = key;
                    slot_val[f] = value;
                    slot_age[f] = 0;
                    touch_slot(f, SLOTS + 1);
                    used_count++;
                end else begin
                    // replace the least recent entry, first slot on a tie
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_used[i] && (v < 0 || slot_age[i] > slot_age[v])) v = i;
                    end
                    if (v >= 0) begin
                        rep.evicted = 1'b1;
                        rep.evicted_key = slot_key[v];
                        slot_key[v] = key;
                        slot_val[v] = value;
                        touch_slot(v, slot_age[v]);
                    end
                end
            end
        end
        replies_due.push_back(rep);
    endtask

    // Request driver: predict on each accepted beat, then present the next
    // pending request or idle for the chosen gap. Valid holds until accepted.
    always @(posedge i_clk) begin
        t_cache_req nxt;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) lru_access(i_kind, i_key, i_value);
            if (!(i_in_valid && !o_in_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    nxt = pending_ops.pop_front();
                    i_kind <= nxt.kind;
                    i_key <= nxt.key;
                    i_value <= nxt.value;
                    i_in_valid <= 1'b1;
                    send_gap = idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each beat against the oldest expected reply,
    // and stall the result channel at random.
    always @(posedge i_clk) begin
        t_cache_reply want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("unexpected result beat: hit=%0b read_value=%h ",
                               o_hit, o_read_value);
                        $display("evicted=%0b evicted_key=%h", o_evicted, o_evicted_key);
                    end
                end else begin
                    want = replies_due.pop_front();
                    if (o_hit !== want.hit || o_read_value !== want.read_value ||
                        o_evicted !== want.evicted || o_evicted_key !== want.evicted_key) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("mismatch: hit %0b/%0b read_value %h/%h ",
                                   want.hit, o_hit, want.read_value, o_read_value);
                            $display("evicted %0b/%0b evicted_key %h/%h (expected/actual)",
                                     want.evicted, o_evicted, want.evicted_key, o_evicted_key);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    task automatic push_op(input logic kind, input logic [31:0] key, input logic [31:0] value);
        t_cache_req r;
        r.kind = kind;
        r.key = key;
        r.value = value;
        pending_ops.push_back(r);
    endtask

    // Wait until every request is accepted and every reply has come back,
    // then let the block go quiet.
    task automatic settle();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || i_in_valid || replies_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CFG_W-1:0] cap);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cap;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_setting = cap;
        @(negedge i_clk);
    endtask

    // Mostly keys from a small pool, sized just past the capacity so hits,
    // updates and evictions all happen; some fully random keys as noise.
    task automatic queue_random(input int n);
        int lim;
        logic kind;
        logic [31:0] key;
        lim = usable_slots() + 4;
        if (lim > 31) lim = 31;
        for (int i = 0; i < 32; i++) key_pool[i] = $urandom;
        for (int i = 0; i < n; i++) begin
            kind = ($urandom_range(0, 99) < 55) ? KIND_PUT : KIND_GET;
            if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, lim)];
            else key = $urandom;
            push_op(kind, key, $urandom);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] caps[10];
        caps = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd5, 5'd2, 5'd20, 5'd8, 5'd3, 5'd12};
        for (int i = 0; i < SLOTS; i++) begin
            slot_key[i] = '0;
            slot_val[i] = '0;
            slot_used[i] = 1'b0;
            slot_age[i] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset capacity: miss on empty, key and value extremes, hits, update.
        push_op(KIND_GET, 32'd0, 32'd0);
        push_op(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        push_op(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        push_op(KIND_PUT, 32'd0, 32'd0);
        push_op(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(KIND_GET, 32'h8000_0000, 32'h1234_5678);
        push_op(KIND_GET, 32'hFFFF_FFFF, 32'd0);
        push_op(KIND_PUT, 32'd0, 32'd123);
        push_op(KIND_GET, 32'd5, 32'd0);
        settle();

        // Lower the capacity below the entry count: update evicts nothing,
        // new keys replace the least recent entry.
        set_capacity(5'd2);
        push_op(KIND_PUT, 32'h7FFF_FFFF, 32'd7);
        push_op(KIND_PUT, 32'd77, 32'd1);
        push_op(KIND_PUT, 32'd78, 32'd2);
        push_op(KIND_GET, 32'd77, 32'd0);
        settle();

        // Capacity zero behaves as one.
        set_capacity(5'd0);
        push_op(KIND_PUT, 32'd1, 32'd10);
        push_op(KIND_PUT, 32'd2, 32'd20);
        push_op(KIND_GET, 32'd1, 32'd0);
        push_op(KIND_GET, 32'd2, 32'd0);
        settle();

        // Random phases across capacities, the extremes among them.
        for (int p = 0; p < 10; p++) begin
            set_capacity(caps[p]);
            calm = (p == 3 || p == 7);
            queue_random(105);
            settle();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
